// ----- src/ebd_pkg.sv -----
// shared types and constants for the encoder and button event decoder
// no dependencies
package ebd_pkg;

  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned TIME_W     = 32;
  localparam int unsigned COUNT_W    = 16;
  localparam int unsigned NUM_BTN    = 3;

  typedef enum logic [0:0] {
    CFG_DEBOUNCE   = 1'b0,
    CFG_LONG_PRESS = 1'b1
  } cfg_idx_t;

  typedef enum logic [2:0] {
    EV_NONE  = 3'd0,
    EV_CW    = 3'd1,
    EV_CCW   = 3'd2,
    EV_LONG  = 3'd3,
    EV_SHORT = 3'd4,
    EV_BTN1  = 3'd5,
    EV_BTN2  = 3'd6,
    EV_BTN3  = 3'd7
  } event_t;

  localparam logic [COUNT_W-1:0] DETENT_STEP = COUNT_W'(4);
  localparam logic [COUNT_W-1:0] CCW_LIMIT   = COUNT_W'(16'hFFFC);

  typedef struct packed {
    logic press;
    logic lift;
  } btn_status_t;

endpackage

// ----- src/ebd_button.sv -----
// debounced press and release detection for one active-low button
// depends on ebd_pkg
module ebd_button (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        level,
  input  logic [ebd_pkg::TIME_W-1:0]  now_ms,
  input  logic [ebd_pkg::CFG_DATA_W-1:0] debounce_ms,
  input  logic                        update,
  output ebd_pkg::btn_status_t        status
);
  import ebd_pkg::*;

  logic              held_r;
  logic              held_nxt;
  logic [TIME_W-1:0] edge_time_r;
  logic [TIME_W-1:0] edge_time_nxt;
  logic [TIME_W-1:0] elapsed;
  logic              settled;

  assign elapsed        = now_ms - edge_time_r;
  assign settled        = elapsed > {{(TIME_W-CFG_DATA_W){1'b0}}, debounce_ms};
  assign status.press   = !level && !held_r && settled;
  assign status.lift    = level && held_r && settled;

  always_comb begin
    held_nxt      = held_r;
    edge_time_nxt = edge_time_r;
    if (update && (status.press || status.lift)) begin
      held_nxt      = status.press;
      edge_time_nxt = now_ms;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r      <= 1'b0;
      edge_time_r <= '0;
    end else begin
      held_r      <= held_nxt;
      edge_time_r <= edge_time_nxt;
    end
  end

endmodule

// ----- src/encoder_button_event_decoder.sv -----
// top level of the rotary encoder and button event decoder
// depends on ebd_pkg and ebd_button
//
// usage:
//   input channel (in_valid/in_ready) carries one pin sample per transfer:
//   encoder A/B levels, encoder switch and three button levels (active low)
//   and a wrapping millisecond time stamp
//   output channel (out_valid/out_ready) returns exactly one event code per
//   sample: none, cw, ccw, long push, short push or button 1..3
//   the sample is decoded in the cycle it is taken; its event is registered
//   in the output register and shown from the next cycle on
//   throughput is one sample per cycle, limited only by the output register
//   in_ready is high whenever the output register is empty or being drained,
//   so a stalled receiver holds the pending event and back-pressures input
//   after one held result
//   cfg_we writes debounce_ms (index 0) or long_press_ms (index 1) at once
//   synchronous reset: debounce 30 ms, long press 800 ms, counters and
//   button/switch state cleared, previous A level taken as high, output empty
module encoder_button_event_decoder (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic                              cfg_index,
  input  logic [ebd_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              in_enc_a_level,
  input  logic                              in_enc_b_level,
  input  logic                              in_enc_switch_level,
  input  logic                              in_button_one_level,
  input  logic                              in_button_two_level,
  input  logic                              in_button_three_level,
  input  logic [ebd_pkg::TIME_W-1:0]        in_now_ms,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [2:0]                        out_event_code
);
  import ebd_pkg::*;

  logic [CFG_DATA_W-1:0] debounce_r;
  logic [CFG_DATA_W-1:0] long_press_r;

  logic                  prev_a_r,      prev_a_nxt;
  logic [COUNT_W-1:0]    quad_count_r,  quad_count_nxt;
  logic [COUNT_W-1:0]    detent_base_r, detent_base_nxt;
  logic                  sw_held_r,     sw_held_nxt;
  logic [TIME_W-1:0]     sw_time_r,     sw_time_nxt;
  logic                  long_rep_r,    long_rep_nxt;
  logic                  out_valid_r;
  event_t                out_event_r,   out_event_nxt;

  logic                  accept;
  logic [COUNT_W-1:0]    quad_step;
  logic [COUNT_W-1:0]    gap;
  logic                  cw_fire;
  logic                  ccw_fire;
  logic                  detent_fire;
  logic                  sw;
  logic                  sw_press;
  logic                  long_eff;
  logic [TIME_W-1:0]     sw_time_eff;
  logic [TIME_W-1:0]     sw_elapsed;
  logic                  long_fire;
  logic                  sw_release;
  logic                  short_fire;
  logic                  sw_fire;
  logic [NUM_BTN-1:0]    btn_level;
  logic [NUM_BTN-1:0]    btn_update;
  btn_status_t           btn_status [NUM_BTN];

  assign in_ready       = !out_valid_r || out_ready;
  assign accept         = in_valid && in_ready;
  assign out_valid      = out_valid_r;
  assign out_event_code = out_event_r;

  // quadrature count and detent compare
  assign quad_step = (in_enc_a_level == in_enc_b_level) ? quad_count_r + COUNT_W'(1)
                                                        : quad_count_r - COUNT_W'(1);
  assign quad_count_nxt = (accept && in_enc_a_level != prev_a_r) ? quad_step : quad_count_r;
  assign prev_a_nxt     = accept ? in_enc_a_level : prev_a_r;

  assign gap         = quad_count_nxt - detent_base_r;
  assign cw_fire     = !gap[COUNT_W-1] && gap >= DETENT_STEP;
  assign ccw_fire    = gap[COUNT_W-1] && gap <= CCW_LIMIT;
  assign detent_fire = cw_fire || ccw_fire;

  always_comb begin
    detent_base_nxt = detent_base_r;
    if (accept && cw_fire) begin
      detent_base_nxt = detent_base_r + DETENT_STEP;
    end else if (accept && ccw_fire) begin
      detent_base_nxt = detent_base_r - DETENT_STEP;
    end
  end

  // encoder push switch
  assign sw          = !in_enc_switch_level;
  assign sw_press    = sw && !sw_held_r;
  assign long_eff    = sw_press ? 1'b0 : long_rep_r;
  assign sw_time_eff = sw_press ? in_now_ms : sw_time_r;
  assign sw_elapsed  = in_now_ms - sw_time_eff;
  assign long_fire   = sw && !long_eff &&
                       sw_elapsed >= {{(TIME_W-CFG_DATA_W){1'b0}}, long_press_r};
  assign sw_release  = !sw && sw_held_r;
  assign short_fire  = sw_release && !long_rep_r &&
                       sw_elapsed > {{(TIME_W-CFG_DATA_W){1'b0}}, debounce_r};
  assign sw_fire     = long_fire || short_fire;

  always_comb begin
    sw_held_nxt  = sw_held_r;
    sw_time_nxt  = sw_time_r;
    long_rep_nxt = long_rep_r;
    if (accept && !detent_fire) begin
      if (sw_press) begin
        sw_held_nxt = 1'b1;
        sw_time_nxt = in_now_ms;
      end
      if (sw_release) begin
        sw_held_nxt = 1'b0;
      end
      long_rep_nxt = long_eff || long_fire;
    end
  end

  // buttons, earlier press masks later ones
  assign btn_level = {in_button_three_level, in_button_two_level, in_button_one_level};

  always_comb begin
    btn_update[0] = accept && !detent_fire && !sw_fire;
    for (int i = 1; i < NUM_BTN; i++) begin
      btn_update[i] = btn_update[i-1] && !btn_status[i-1].press;
    end
  end

  for (genvar g = 0; g < NUM_BTN; g++) begin : g_btn
    ebd_button u_btn (
      .clk         (clk),
      .rst_n       (rst_n),
      .level       (btn_level[g]),
      .now_ms      (in_now_ms),
      .debounce_ms (debounce_r),
      .update      (btn_update[g]),
      .status      (btn_status[g])
    );
  end

  always_comb begin
    priority if (cw_fire) begin
      out_event_nxt = EV_CW;
    end else if (ccw_fire) begin
      out_event_nxt = EV_CCW;
    end else if (long_fire) begin
      out_event_nxt = EV_LONG;
    end else if (short_fire) begin
      out_event_nxt = EV_SHORT;
    end else if (btn_status[0].press) begin
      out_event_nxt = EV_BTN1;
    end else if (btn_status[1].press) begin
      out_event_nxt = EV_BTN2;
    end else if (btn_status[2].press) begin
      out_event_nxt = EV_BTN3;
    end else begin
      out_event_nxt = EV_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_r   <= CFG_DATA_W'(30);
      long_press_r <= CFG_DATA_W'(800);
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_DEBOUNCE:   debounce_r   <= cfg_wdata;
        CFG_LONG_PRESS: long_press_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_a_r      <= 1'b1;
      quad_count_r  <= '0;
      detent_base_r <= '0;
      sw_held_r     <= 1'b0;
      sw_time_r     <= '0;
      long_rep_r    <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      prev_a_r      <= prev_a_nxt;
      quad_count_r  <= quad_count_nxt;
      detent_base_r <= detent_base_nxt;
      sw_held_r     <= sw_held_nxt;
      sw_time_r     <= sw_time_nxt;
      long_rep_r    <= long_rep_nxt;
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_event_r <= out_event_nxt;
    end
  end

endmodule

// ----- sim/tb_top.sv -----
// testbench for encoder_button_event_decoder: random and directed pin samples,
// a scoreboard with its own event decoder checking every event code in order
// depends on ebd_pkg and the rtl top level
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import ebd_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_ITEMS = 1130;

  typedef struct packed {
    logic        enc_a;
    logic        enc_b;
    logic        enc_switch;
    logic        button_one;
    logic        button_two;
    logic        button_three;
    logic [31:0] now_ms;
  } pin_sample_t;

  class decoder_scoreboard;
    logic [15:0] debounce_ms;
    logic [15:0] long_press_ms;
    logic        last_a;
    logic [15:0] quad_count;
    logic [15:0] detent_base;
    logic        switch_down;
    logic [31:0] switch_down_ms;
    logic        long_sent;
    logic [2:0]  button_down;
    logic [31:0] button_edge_ms [3];
    event_t      pending_events[$];
    int          errors;

    function new();
      debounce_ms    = 16'd30;
      long_press_ms  = 16'd800;
      last_a         = 1'b1;
      quad_count     = '0;
      detent_base    = '0;
      switch_down    = 1'b0;
      switch_down_ms = '0;
      long_sent      = 1'b0;
      button_down    = '0;
      for (int i = 0; i < 3; i++) button_edge_ms[i] = '0;
      errors = 0;
    endfunction

    function void set_register(cfg_idx_t idx, logic [15:0] value);
      if (idx == CFG_DEBOUNCE) begin
        debounce_ms = value;
      end else begin
        long_press_ms = value;
      end
    endfunction

    function event_t decode(pin_sample_t s);
      logic [15:0] gap;
      logic [31:0] elapsed;
      logic [2:0]  level;
      logic        pressed;
      event_t      button_events [3];
      button_events = '{EV_BTN1, EV_BTN2, EV_BTN3};
      if (s.enc_a != last_a) begin
        if (s.enc_a == s.enc_b) quad_count = quad_count + 16'd1;
        else quad_count = quad_count - 16'd1;
        last_a = s.enc_a;
      end
      gap = quad_count - detent_base;
      if (gap >= DETENT_STEP && gap < 16'h8000) begin
        detent_base = detent_base + DETENT_STEP;
        return EV_CW;
      end
      if (gap >= 16'h8000 && gap <= CCW_LIMIT) begin
        detent_base = detent_base - DETENT_STEP;
        return EV_CCW;
      end
      pressed = !s.enc_switch;
      if (pressed && !switch_down) begin
        switch_down    = 1'b1;
        switch_down_ms = s.now_ms;
        long_sent      = 1'b0;
      end
      elapsed = s.now_ms - switch_down_ms;
      if (pressed && switch_down && !long_sent && elapsed >= {16'd0, long_press_ms}) begin
        long_sent = 1'b1;
        return EV_LONG;
      end
      if (!pressed && switch_down) begin
        switch_down = 1'b0;
        if (!long_sent && elapsed > {16'd0, debounce_ms}) return EV_SHORT;
      end
      level = {s.button_three, s.button_two, s.button_one};
      for (int i = 0; i < 3; i++) begin
        elapsed = s.now_ms - button_edge_ms[i];
        if (!level[i] && !button_down[i] && elapsed > {16'd0, debounce_ms}) begin
          button_down[i]    = 1'b1;
          button_edge_ms[i] = s.now_ms;
          return button_events[i];
        end
        if (level[i] && button_down[i] && elapsed > {16'd0, debounce_ms}) begin
          button_down[i]    = 1'b0;
          button_edge_ms[i] = s.now_ms;
        end
      end
      return EV_NONE;
    endfunction

    function void note_sample(pin_sample_t s);
      pending_events.push_back(decode(s));
    endfunction

    function void check_event(logic [2:0] code);
      event_t want;
      if (pending_events.size() == 0) begin
        $display("%0t unexpected event: expected nothing, actual %0d", $time, code);
        errors++;
        return;
      end
      want = pending_events.pop_front();
      if (code !== want) begin
        $display("%0t event_code mismatch: expected %0d (%s), actual %0d",
                 $time, want, want.name(), code);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic        cfg_index = 1'b0;
  logic [15:0] cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        in_enc_a_level = 1'b1;
  logic        in_enc_b_level = 1'b1;
  logic        in_enc_switch_level = 1'b1;
  logic        in_button_one_level = 1'b1;
  logic        in_button_two_level = 1'b1;
  logic        in_button_three_level = 1'b1;
  logic [31:0] in_now_ms = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  out_event_code;

  decoder_scoreboard sb = new();

  int          send_idle_pct = 0;
  int          stall_pct = 0;
  int          hold_cycles = 0;
  int          cycle_count = 0;

  logic [1:0]  enc_pos = 2'd0;
  logic        enc_cw = 1'b1;
  logic [3:0]  pin_levels = 4'hF;
  logic [31:0] clock_ms = 32'd0;
  int          step_max = 10;

  localparam logic [1:0] GRAY [4] = '{2'b00, 2'b01, 2'b11, 2'b10};

  encoder_button_event_decoder DUT (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cfg_we                (cfg_we),
    .cfg_index             (cfg_index),
    .cfg_wdata             (cfg_wdata),
    .in_valid              (in_valid),
    .in_ready              (in_ready),
    .in_enc_a_level        (in_enc_a_level),
    .in_enc_b_level        (in_enc_b_level),
    .in_enc_switch_level   (in_enc_switch_level),
    .in_button_one_level   (in_button_one_level),
    .in_button_two_level   (in_button_two_level),
    .in_button_three_level (in_button_three_level),
    .in_now_ms             (in_now_ms),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_event_code        (out_event_code)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // receiver side: long hold-off when asked, random stalls otherwise
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      out_ready = 1'b0;
      hold_cycles--;
    end else begin
      out_ready = ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_event(out_event_code);
  end

  // pins ordered a, b, switch, button one, two, three
  function automatic pin_sample_t mk(logic [5:0] pins, logic [31:0] now);
    pin_sample_t s;
    s = '{pins[5], pins[4], pins[3], pins[2], pins[1], pins[0], now};
    return s;
  endfunction

  function automatic pin_sample_t random_sample();
    pin_sample_t s;
    if ($urandom_range(99) < 8) begin
      s = '{1'($urandom_range(1)), 1'($urandom_range(1)), 1'($urandom_range(1)),
            1'($urandom_range(1)), 1'($urandom_range(1)), 1'($urandom_range(1)),
            $urandom()};
      clock_ms = s.now_ms;
      return s;
    end
    if ($urandom_range(9) == 0) enc_cw = ~enc_cw;
    if ($urandom_range(3) != 0) enc_pos = enc_cw ? enc_pos + 2'd1 : enc_pos - 2'd1;
    if ($urandom_range(7) == 0) pin_levels[0] = ~pin_levels[0];
    for (int i = 1; i < 4; i++) begin
      if ($urandom_range(5) == 0) pin_levels[i] = ~pin_levels[i];
    end
    clock_ms = clock_ms + $urandom_range(step_max);
    if ($urandom_range(49) == 0) clock_ms = clock_ms + $urandom_range(2000);
    if ($urandom_range(39) == 0) clock_ms = clock_ms + $urandom_range(70000);
    s = '{GRAY[enc_pos][1], GRAY[enc_pos][0], pin_levels[0], pin_levels[1],
          pin_levels[2], pin_levels[3], clock_ms};
    return s;
  endfunction

  // called at a falling edge; returns at the falling edge after the transfer
  task automatic send_sample(input pin_sample_t s);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid              = 1'b1;
    in_enc_a_level        = s.enc_a;
    in_enc_b_level        = s.enc_b;
    in_enc_switch_level   = s.enc_switch;
    in_button_one_level   = s.button_one;
    in_button_two_level   = s.button_two;
    in_button_three_level = s.button_three;
    in_now_ms             = s.now_ms;
    do @(posedge clk); while (!in_ready);
    sb.note_sample(s);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid = 1'b0;
    while (sb.pending_events.size() != 0) @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  task automatic write_register(input cfg_idx_t idx, input logic [15:0] value);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = value;
    @(negedge clk);
    cfg_we = 1'b0;
    sb.set_register(idx, value);
  endtask

  task automatic run_phase(input logic [15:0] debounce, input logic [15:0] long_press,
                           input int items, input int idle_pct, input int stall,
                           input int steps, input logic hold_mid, input logic pause_mid);
    wait_drained();
    write_register(CFG_DEBOUNCE, debounce);
    write_register(CFG_LONG_PRESS, long_press);
    send_idle_pct = idle_pct;
    stall_pct     = stall;
    step_max      = steps;
    for (int n = 0; n < items; n++) begin
      if (n == items / 2) begin
        if (hold_mid) hold_cycles = 80;
        if (pause_mid) wait_drained();
      end
      send_sample(random_sample());
    end
  endtask

  initial begin
    repeat (5) @(negedge clk);
    rst_n = 1'b1;

    // detent steps, first sample with a low counts as an edge
    send_sample(mk(6'b001111, 32'd0));
    send_sample(mk(6'b111111, 32'd1));
    send_sample(mk(6'b001111, 32'd2));
    send_sample(mk(6'b110011, 32'd3));
    send_sample(mk(6'b011111, 32'd4));
    send_sample(mk(6'b101111, 32'd5));
    send_sample(mk(6'b011111, 32'd6));
    send_sample(mk(6'b101111, 32'd7));
    // long push, then short push, then a switch bounce
    send_sample(mk(6'b100111, 32'd100));
    send_sample(mk(6'b100111, 32'd500));
    send_sample(mk(6'b100111, 32'd900));
    send_sample(mk(6'b101111, 32'd950));
    send_sample(mk(6'b100111, 32'd1000));
    send_sample(mk(6'b101111, 32'd1040));
    send_sample(mk(6'b100111, 32'd1100));
    send_sample(mk(6'b101111, 32'd1120));
    // buttons: single, two at once, release with later buttons, bounce
    send_sample(mk(6'b101011, 32'd1200));
    send_sample(mk(6'b101000, 32'd1300));
    send_sample(mk(6'b101000, 32'd1301));
    send_sample(mk(6'b101100, 32'd1310));
    send_sample(mk(6'b101000, 32'd1320));
    send_sample(mk(6'b101111, 32'd1400));
    // short push across the time wrap, then all pins low at the top time
    send_sample(mk(6'b100111, 32'hFFFF_FFF0));
    send_sample(mk(6'b101111, 32'h0000_0020));
    send_sample(mk(6'b000000, 32'hFFFF_FFFF));
    clock_ms = 32'd2000;

    run_phase(16'd5, 16'd60, RANDOM_ITEMS / 6, 0, 0, 8, 1'b0, 1'b0);
    run_phase(16'd0, 16'd0, RANDOM_ITEMS / 6, 65, 0, 4, 1'b0, 1'b1);
    clock_ms = 32'hFFFF_F000;
    run_phase(16'd65535, 16'd65535, RANDOM_ITEMS / 6, 0, 65, 30, 1'b1, 1'b0);
    run_phase(16'd20, 16'd300, RANDOM_ITEMS / 6, 27, 27, 12, 1'b0, 1'b0);
    run_phase(16'd12, 16'd40, RANDOM_ITEMS / 6, 0, 0, 6, 1'b1, 1'b1);
    run_phase(16'd30, 16'd800, RANDOM_ITEMS - 5 * (RANDOM_ITEMS / 6), 27, 27, 40,
              1'b0, 1'b0);

    wait_drained();
    repeat (5) @(posedge clk);
    if (sb.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
